FILE: hdl/ilex_pkg.sv
package ilex_pkg;

  localparam int LINE_BITS      = 24;
  localparam int COLUMN_BITS    = 16;
  localparam int POSITION_BITS  = 32;
  localparam int KIND_BITS      = 2;
  localparam int CHAR_BITS      = 8;

  // power of two, so the pointers wrap on their own
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_BITS-1:0] KIND_IDENT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_INT   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL        = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_LF         = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CHAR_SLASH      = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CHAR_STAR       = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5F;

  // results caused by one item: an optional token, then an optional end token
  typedef struct packed {
    logic                     tok_valid;
    logic                     end_valid;
    logic [KIND_BITS-1:0]     kind;
    logic [LINE_BITS-1:0]     line;
    logic [COLUMN_BITS-1:0]   column;
    logic [COLUMN_BITS-1:0]   length;
    logic [POSITION_BITS-1:0] position;
    logic [COLUMN_BITS-1:0]   end_column;
    logic [POSITION_BITS-1:0] end_position;
  } entry_t;

  function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CHAR_UNDERSCORE;
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

FILE: hdl/ilex_front.sv
module ilex_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ilex_pkg::CHAR_BITS-1:0] character,
  input  logic                           q_full,
  output logic                           push,
  output ilex_pkg::entry_t               entry
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_SLASH,
    MODE_LINE_CMT,
    MODE_BLOCK_CMT,
    MODE_BLOCK_STAR
  } mode_t;

  mode_t                                mode, mode_next;
  logic [ilex_pkg::LINE_BITS-1:0]       line_count, line_count_next;
  logic [ilex_pkg::COLUMN_BITS-1:0]     column_count, column_count_next;
  logic [ilex_pkg::POSITION_BITS-1:0]   byte_position, byte_position_next;
  logic [ilex_pkg::COLUMN_BITS-1:0]     start_column, start_column_next;
  logic [ilex_pkg::POSITION_BITS-1:0]   start_position, start_position_next;
  logic [ilex_pkg::COLUMN_BITS-1:0]     run_length, run_length_next;

  logic [ilex_pkg::LINE_BITS-1:0]       line_adv;
  logic [ilex_pkg::COLUMN_BITS-1:0]     column_adv;
  logic [ilex_pkg::POSITION_BITS-1:0]   position_adv;
  logic [ilex_pkg::COLUMN_BITS-1:0]     run_inc;
  logic                                 accept;
  logic                                 emit_tok;
  logic                                 emit_end;
  logic                                 rescan;
  logic                                 letter;
  logic                                 digit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign letter   = ilex_pkg::is_letter(character);
  assign digit    = ilex_pkg::is_digit(character);

  // saturating counters after this byte
  assign line_adv = (character != ilex_pkg::CHAR_LF) ? line_count :
                    (&line_count) ? line_count : line_count + 1'b1;
  assign column_adv = (character == ilex_pkg::CHAR_LF) ? '0 :
                      (&column_count) ? column_count : column_count + 1'b1;
  assign position_adv = (&byte_position) ? byte_position : byte_position + 1'b1;
  assign run_inc = (&run_length) ? run_length : run_length + 1'b1;

  always_comb begin
    mode_next           = mode;
    line_count_next     = line_count;
    column_count_next   = column_count;
    byte_position_next  = byte_position;
    start_column_next   = start_column;
    start_position_next = start_position;
    run_length_next     = run_length;
    emit_tok            = 1'b0;
    emit_end            = 1'b0;
    rescan              = 1'b0;

    case (mode)
      MODE_IDENT, MODE_INT: begin
        if (digit || (mode == MODE_IDENT && letter)) begin
          run_length_next = run_inc;
        end else begin
          emit_tok = 1'b1;
          rescan   = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (character == ilex_pkg::CHAR_SLASH) begin
          mode_next = MODE_LINE_CMT;
        end else if (character == ilex_pkg::CHAR_STAR) begin
          mode_next = MODE_BLOCK_CMT;
        end else begin
          rescan = 1'b1;
        end
      end
      MODE_LINE_CMT: begin
        if (character == ilex_pkg::CHAR_NUL || character == ilex_pkg::CHAR_LF) begin
          rescan = 1'b1;
        end
      end
      MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
        if (character == ilex_pkg::CHAR_NUL) begin
          rescan = 1'b1;
        end else if (mode == MODE_BLOCK_STAR && character == ilex_pkg::CHAR_SLASH) begin
          mode_next = MODE_IDLE;
        end else if (character == ilex_pkg::CHAR_STAR) begin
          mode_next = MODE_BLOCK_STAR;
        end else begin
          mode_next = MODE_BLOCK_CMT;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // scan the byte from idle: end of text, slash, or start of a token
    if (rescan) begin
      mode_next = MODE_IDLE;
      if (character == ilex_pkg::CHAR_NUL) begin
        emit_end = 1'b1;
      end else if (character == ilex_pkg::CHAR_SLASH) begin
        mode_next = MODE_SLASH;
      end else if (letter || digit) begin
        mode_next           = letter ? MODE_IDENT : MODE_INT;
        start_column_next   = column_count;
        start_position_next = byte_position;
        run_length_next     = ilex_pkg::COLUMN_BITS'(1);
      end
    end

    if (emit_end) begin
      line_count_next     = '0;
      column_count_next   = '0;
      byte_position_next  = '0;
      start_column_next   = '0;
      start_position_next = '0;
      run_length_next     = '0;
    end else begin
      line_count_next     = line_adv;
      column_count_next   = column_adv;
      byte_position_next  = position_adv;
    end
  end

  assign push = accept && (emit_tok || emit_end);

  always_comb begin
    entry.tok_valid    = emit_tok;
    entry.end_valid    = emit_end;
    entry.kind         = (mode == MODE_IDENT) ? ilex_pkg::KIND_IDENT : ilex_pkg::KIND_INT;
    entry.line         = line_count;
    entry.column       = start_column;
    entry.length       = run_length;
    entry.position     = start_position;
    entry.end_column   = column_count;
    entry.end_position = byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      line_count     <= '0;
      column_count   <= '0;
      byte_position  <= '0;
      start_column   <= '0;
      start_position <= '0;
      run_length     <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      byte_position  <= byte_position_next;
      start_column   <= start_column_next;
      start_position <= start_position_next;
      run_length     <= run_length_next;
    end
  end

endmodule

FILE: hdl/ilex_queue.sv
module ilex_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ilex_pkg::entry_t wr_entry,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output ilex_pkg::entry_t head
);

  ilex_pkg::entry_t                       slots [ilex_pkg::QUEUE_DEPTH];
  logic [ilex_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr;
  logic [ilex_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr;
  logic [ilex_pkg::QUEUE_PTR_BITS:0]      count;

  assign full  = count == (ilex_pkg::QUEUE_PTR_BITS + 1)'(ilex_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/ilex_back.sv
module ilex_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               empty,
  input  ilex_pkg::entry_t                   head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ilex_pkg::KIND_BITS-1:0]     token_kind,
  output logic [ilex_pkg::LINE_BITS-1:0]     token_line,
  output logic [ilex_pkg::COLUMN_BITS-1:0]   token_column,
  output logic [ilex_pkg::COLUMN_BITS-1:0]   token_length,
  output logic [ilex_pkg::POSITION_BITS-1:0] token_position,
  output logic                               last_of_run
);

  logic load;
  logic tok_phase;
  logic end_pending;

  assign load      = !out_valid || out_ready;
  assign tok_phase = head.tok_valid && !end_pending;
  // hold the entry while its end token is still to come
  assign pop       = load && !empty && !(tok_phase && head.end_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      end_pending <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        end_pending <= tok_phase && head.end_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      token_line <= head.line;
      if (tok_phase) begin
        token_kind     <= head.kind;
        token_column   <= head.column;
        token_length   <= head.length;
        token_position <= head.position;
        last_of_run    <= !head.end_valid;
      end else begin
        token_kind     <= ilex_pkg::KIND_END;
        token_column   <= head.end_column;
        token_length   <= '0;
        token_position <= head.end_position;
        last_of_run    <= 1'b1;
      end
    end
  end

endmodule

FILE: hdl/identifier_integer_lexer.sv
// Identifier and integer lexer, one source byte per item.
// Throughput: one item per cycle while the queue is not full; an item that closes a
// token at the end of text gives two results, the token and then the end token.
// Each result is written into a four-entry queue between the scanner and the output
// register, and is shown from the output register.
// Reset: synchronous, clears the scanner to idle with all counters at zero.
module identifier_integer_lexer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ilex_pkg::CHAR_BITS-1:0]     character,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ilex_pkg::KIND_BITS-1:0]     token_kind,
  output logic [ilex_pkg::LINE_BITS-1:0]     token_line,
  output logic [ilex_pkg::COLUMN_BITS-1:0]   token_column,
  output logic [ilex_pkg::COLUMN_BITS-1:0]   token_length,
  output logic [ilex_pkg::POSITION_BITS-1:0] token_position,
  output logic                               last_of_run
);

  ilex_pkg::entry_t wr_entry;
  ilex_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  ilex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .q_full    (q_full),
    .push      (push),
    .entry     (wr_entry)
  );

  ilex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  ilex_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .token_kind     (token_kind),
    .token_line     (token_line),
    .token_column   (token_column),
    .token_length   (token_length),
    .token_position (token_position),
    .last_of_run    (last_of_run)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue written while full");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind == ilex_pkg::KIND_END) |-> (last_of_run && token_length == '0))
    else $error("end token not last or with nonzero length");

  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=>
      (out_valid && token_kind == ilex_pkg::KIND_END))
    else $error("token closed by end of text not followed by end token");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue read while empty");
`endif

endmodule
